>>> rtl/hmdp_pkg.sv
// Package for the HID mouse descriptor parser: item codes, usage codes,
// field widths and the result record type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hmdp_pkg;

   // Item field widths.
   localparam int KIND_W  = 2;
   localparam int TAG_W   = 4;
   localparam int NBYTE_W = 3;
   localparam int VALUE_W = 32;

   // Result field widths.
   localparam int BYTE_W   = 13;
   localparam int BITS_W   = 8;
   localparam int COUNT_W  = 8;
   localparam int AXBITS_W = 5;
   localparam int RLEN_W   = 14;

   localparam int OFFSET_WIDTH_DEF = 16;

   // Item types.
   localparam logic [KIND_W-1:0] KIND_MAIN   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_GLOBAL = 2'd1;
   localparam logic [KIND_W-1:0] KIND_LOCAL  = 2'd2;

   // Main item tags.
   localparam logic [TAG_W-1:0] TAG_INPUT      = 4'd8;
   localparam logic [TAG_W-1:0] TAG_BEGIN_COLL = 4'd10;
   localparam logic [TAG_W-1:0] TAG_END_COLL   = 4'd12;
   // Global item tags.
   localparam logic [TAG_W-1:0] TAG_USAGE_PAGE   = 4'd0;
   localparam logic [TAG_W-1:0] TAG_REPORT_SIZE  = 4'd7;
   localparam logic [TAG_W-1:0] TAG_REPORT_ID    = 4'd8;
   localparam logic [TAG_W-1:0] TAG_REPORT_COUNT = 4'd9;
   // Local item tags.
   localparam logic [TAG_W-1:0] TAG_USAGE = 4'd0;

   // Data length codes.
   localparam logic [NBYTE_W-1:0] NBYTES_0 = 3'd0;
   localparam logic [NBYTE_W-1:0] NBYTES_1 = 3'd1;
   localparam logic [NBYTE_W-1:0] NBYTES_2 = 3'd2;

   // Pages and extended usages.
   localparam logic [15:0] PAGE_DESKTOP  = 16'h0001;
   localparam logic [15:0] PAGE_BUTTON   = 16'h0009;
   localparam logic [31:0] USAGE_POINTER = 32'h0001_0001;
   localparam logic [31:0] USAGE_MOUSE   = 32'h0001_0002;
   localparam logic [31:0] USAGE_X       = 32'h0001_0030;
   localparam logic [31:0] USAGE_Y       = 32'h0001_0031;
   localparam logic [31:0] USAGE_WHEEL   = 32'h0001_0038;

   localparam logic [7:0] SIZE_AXIS_8  = 8'd8;
   localparam logic [7:0] SIZE_AXIS_16 = 8'd16;
   localparam logic [7:0] COUNT_AXIS   = 8'd2;

   typedef struct packed {
      logic                status;
      logic [BYTE_W-1:0]   button_byte;
      logic [BITS_W-1:0]   button_bits;
      logic [COUNT_W-1:0]  button_count;
      logic [BYTE_W-1:0]   axis_byte;
      logic [AXBITS_W-1:0] axis_bits;
      logic                wheel_found;
      logic [BYTE_W-1:0]   wheel_byte;
      logic [BITS_W-1:0]   wheel_bits;
      logic [RLEN_W-1:0]   report_bytes;
      logic                report_id_declared;
   } hmdp_rsp_type;

endpackage

`default_nettype wire

>>> rtl/hmdp_req_if.sv
// Input channel of the HID mouse descriptor parser: one decoded short item.
// Depends on hmdp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface hmdp_req_if import hmdp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  item_kind;
   logic [TAG_W-1:0]   item_tag;
   logic [NBYTE_W-1:0] data_bytes;
   logic [VALUE_W-1:0] item_value;
   logic               final_item;

   modport source (output valid, item_kind, item_tag, data_bytes, item_value, final_item,
                   input ready);
   modport sink   (input valid, item_kind, item_tag, data_bytes, item_value, final_item,
                   output ready);
endinterface

`default_nettype wire

>>> rtl/hmdp_rsp_if.sv
// Result channel of the HID mouse descriptor parser: one field layout item.
// Depends on hmdp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface hmdp_rsp_if import hmdp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                status;
   logic [BYTE_W-1:0]   button_byte;
   logic [BITS_W-1:0]   button_bits;
   logic [COUNT_W-1:0]  button_count;
   logic [BYTE_W-1:0]   axis_byte;
   logic [AXBITS_W-1:0] axis_bits;
   logic                wheel_found;
   logic [BYTE_W-1:0]   wheel_byte;
   logic [BITS_W-1:0]   wheel_bits;
   logic [RLEN_W-1:0]   report_bytes;
   logic                report_id_declared;

   modport source (output valid, status, button_byte, button_bits, button_count,
                   axis_byte, axis_bits, wheel_found, wheel_byte, wheel_bits,
                   report_bytes, report_id_declared,
                   input ready);
   modport sink   (input valid, status, button_byte, button_bits, button_count,
                   axis_byte, axis_bits, wheel_found, wheel_byte, wheel_bits,
                   report_bytes, report_id_declared,
                   output ready);
endinterface

`default_nettype wire

>>> rtl/hid_mouse_descriptor_parser_top.sv
// An item waits in the input register until the result register can take what it produces;
// a result it causes goes into the result register. Throughput: one item per cycle unless
// a waiting result stalls it; the whole parse step (one 8x8 multiply-add and compares) runs
// between the input register and the result register, which also acts as output buffer.
// Reset (synchronous, active high) empties both registers and returns all parser state to zero.
// Depends on hmdp_pkg, hmdp_req_if and hmdp_rsp_if.
`timescale 1ns / 1ps
`default_nettype none

module hid_mouse_descriptor_parser_top
   import hmdp_pkg::*;
#(
   parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
   input  wire        clock,
   input  wire        reset,
   hmdp_req_if.sink   req_if,
   hmdp_rsp_if.source rsp_if
);

   // The offset arithmetic is carried in a width that holds both the offset and the
   // 16-bit size times count product, plus one bit so that the saturation compare
   // and the round-up to bytes never wrap.
   localparam int SUM_W = ((OFFSET_WIDTH > 16) ? OFFSET_WIDTH : 16) + 1;
   localparam logic [SUM_W-1:0] OFF_MAX =
      {{(SUM_W - OFFSET_WIDTH){1'b0}}, {OFFSET_WIDTH{1'b1}}};

   // ------------------------------------------------------------------
   // Input register. It takes a new item whenever it is empty or its
   // current item moves into the parse step in the same cycle.
   // ------------------------------------------------------------------
   logic               in_valid_ff;
   logic [KIND_W-1:0]  kind_ff;
   logic [TAG_W-1:0]   tag_ff;
   logic [NBYTE_W-1:0] nbytes_ff;
   logic [VALUE_W-1:0] value_ff;
   logic               last_ff;

   logic rsp_valid_ff;
   logic advance;

   // The parse step fires when an item is present and the result register can take
   // whatever the item produces.
   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         kind_ff   <= req_if.item_kind;
         tag_ff    <= req_if.item_tag;
         nbytes_ff <= req_if.data_bytes;
         value_ff  <= req_if.item_value;
         last_ff   <= req_if.final_item;
      end
   end

   // ------------------------------------------------------------------
   // Parser state.
   // ------------------------------------------------------------------
   logic [15:0]             page_ff,      page_in;
   logic [31:0]             usage_ff,     usage_in;
   logic [7:0]              size_ff,      size_in;
   logic [7:0]              count_ff,     count_in;
   logic [OFFSET_WIDTH-1:0] offset_ff,    offset_in;
   logic [7:0]              depth_ff,     depth_in;
   logic                    in_ptr_ff,    in_ptr_in;
   logic                    found_btn_ff, found_btn_in;
   logic                    found_ax_ff,  found_ax_in;
   logic                    found_wh_ff,  found_wh_in;
   logic                    id_seen_ff,   id_seen_in;
   logic                    finished_ff,  finished_in;
   logic [BYTE_W-1:0]       btn_byte_ff,  btn_byte_in;
   logic [BITS_W-1:0]       btn_bits_ff,  btn_bits_in;
   logic [COUNT_W-1:0]      btn_count_ff, btn_count_in;
   logic [BYTE_W-1:0]       ax_byte_ff,   ax_byte_in;
   logic [AXBITS_W-1:0]     ax_bits_ff,   ax_bits_in;
   logic [BYTE_W-1:0]       wh_byte_ff,   wh_byte_in;
   logic [BITS_W-1:0]       wh_bits_ff,   wh_bits_in;

   // ------------------------------------------------------------------
   // Parse step.
   // ------------------------------------------------------------------
   logic [VALUE_W-1:0] val;
   logic [7:0]         val_sat;
   logic [SUM_W-1:0]   off_ext;
   logic [15:0]        product;
   logic [SUM_W-1:0]   off_sum;
   logic [SUM_W-1:0]   off_adv;
   logic [BYTE_W-1:0]  byte_pos;
   logic [7:0]         depth_dec;
   logic               is_xy;
   logic               axis_size_ok;
   logic               close_hit;
   logic               emit_now;
   logic [SUM_W-1:0]   off_round;
   hmdp_rsp_type       result;

   // Only the declared data bytes of an item count; lengths other than 0, 1 and 2
   // keep all four bytes.
   always_comb begin
      unique case (nbytes_ff)
         NBYTES_0: val = '0;
         NBYTES_1: val = {24'd0, value_ff[7:0]};
         NBYTES_2: val = {16'd0, value_ff[15:0]};
         default:  val = value_ff;
      endcase
   end

   assign val_sat = (|val[31:8]) ? 8'hFF : val[7:0];

   // The running offset advances by size times count of each Input item and
   // sticks at its largest value.
   assign off_ext  = SUM_W'(offset_ff);
   assign product  = size_ff * count_ff;
   assign off_sum  = off_ext + SUM_W'(product);
   assign off_adv  = (off_sum > OFF_MAX) ? OFF_MAX : off_sum;
   assign byte_pos = off_ext[15:3];

   assign depth_dec    = (depth_ff == 8'd0) ? 8'd0 : depth_ff - 8'd1;
   assign is_xy        = (usage_ff == USAGE_X) || (usage_ff == USAGE_Y);
   assign axis_size_ok = ((size_ff == SIZE_AXIS_8) || (size_ff == SIZE_AXIS_16)) &&
                         (count_ff == COUNT_AXIS);

   always_comb begin
      page_in      = page_ff;
      usage_in     = usage_ff;
      size_in      = size_ff;
      count_in     = count_ff;
      offset_in    = offset_ff;
      depth_in     = depth_ff;
      in_ptr_in    = in_ptr_ff;
      found_btn_in = found_btn_ff;
      found_ax_in  = found_ax_ff;
      found_wh_in  = found_wh_ff;
      id_seen_in   = id_seen_ff;
      btn_byte_in  = btn_byte_ff;
      btn_bits_in  = btn_bits_ff;
      btn_count_in = btn_count_ff;
      ax_byte_in   = ax_byte_ff;
      ax_bits_in   = ax_bits_ff;
      wh_byte_in   = wh_byte_ff;
      wh_bits_in   = wh_bits_ff;
      close_hit    = 1'b0;

      // After a result from a closing mouse collection, every item up to the last
      // one is ignored.
      if (!finished_ff) begin
         unique case (kind_ff)
            KIND_GLOBAL: begin
               unique case (tag_ff)
                  TAG_USAGE_PAGE: begin
                     page_in = val[15:0];
                  end
                  TAG_REPORT_SIZE: begin
                     size_in = val_sat;
                  end
                  TAG_REPORT_COUNT: begin
                     count_in = val_sat;
                  end
                  TAG_REPORT_ID: begin
                     id_seen_in = 1'b1;
                  end
                  default: begin
                     // Other global items change nothing.
                  end
               endcase
            end
            KIND_LOCAL: begin
               if (tag_ff == TAG_USAGE) begin
                  usage_in = {page_ff, 16'd0} | val;
               end
            end
            KIND_MAIN: begin
               unique case (tag_ff)
                  TAG_BEGIN_COLL: begin
                     depth_in = (depth_ff == 8'hFF) ? depth_ff : depth_ff + 8'd1;
                     // Entering a mouse or pointer collection starts a fresh layout.
                     if (((usage_ff == USAGE_MOUSE) || (usage_ff == USAGE_POINTER)) &&
                         !in_ptr_ff) begin
                        in_ptr_in    = 1'b1;
                        found_btn_in = 1'b0;
                        found_ax_in  = 1'b0;
                        found_wh_in  = 1'b0;
                        offset_in    = '0;
                     end
                  end
                  TAG_END_COLL: begin
                     depth_in = depth_dec;
                     if (in_ptr_ff && (depth_dec == 8'd0)) begin
                        in_ptr_in = 1'b0;
                        close_hit = found_btn_ff && found_ax_ff;
                     end
                  end
                  TAG_INPUT: begin
                     if (in_ptr_ff) begin
                        if (page_ff == PAGE_BUTTON) begin
                           if (!found_btn_ff) begin
                              btn_byte_in  = byte_pos;
                              btn_bits_in  = size_ff;
                              btn_count_in = count_ff;
                              found_btn_in = 1'b1;
                           end
                        end else if (page_ff == PAGE_DESKTOP) begin
                           if (is_xy && !found_ax_ff && axis_size_ok) begin
                              ax_byte_in  = byte_pos;
                              ax_bits_in  = size_ff[AXBITS_W-1:0];
                              found_ax_in = 1'b1;
                           end else if ((usage_ff == USAGE_WHEEL) && !found_wh_ff) begin
                              wh_byte_in  = byte_pos;
                              wh_bits_in  = size_ff;
                              found_wh_in = 1'b1;
                           end
                        end
                     end
                     offset_in = off_adv[OFFSET_WIDTH-1:0];
                     usage_in  = '0;
                  end
                  default: begin
                     // Output, Feature and unknown main items change nothing.
                  end
               endcase
            end
            default: begin
               // Reserved item type: nothing changes.
            end
         endcase
      end
   end

   // A result leaves on a closing mouse collection with buttons and axes, or on the
   // last item of a descriptor that has not given one yet.
   assign emit_now    = !finished_ff && (close_hit || last_ff);
   assign finished_in = finished_ff || close_hit;

   // The result reflects the state after the item took effect.
   assign off_round = SUM_W'(offset_in) + SUM_W'(7);

   always_comb begin
      result = '0;
      if (found_btn_in && found_ax_in) begin
         result.status       = 1'b0;
         result.button_byte  = btn_byte_in;
         result.button_bits  = btn_bits_in;
         result.button_count = btn_count_in;
         result.axis_byte    = ax_byte_in;
         result.axis_bits    = ax_bits_in;
         if (found_wh_in) begin
            result.wheel_found = 1'b1;
            result.wheel_byte  = wh_byte_in;
            result.wheel_bits  = wh_bits_in;
         end
         result.report_bytes       = off_round[16:3];
         result.report_id_declared = id_seen_in;
      end else begin
         // Missing buttons or axes: every field but the status stays zero.
         result.status = 1'b1;
      end
   end

   // The last item of a descriptor returns all state to reset after it is handled.
   always_ff @(posedge clock) begin
      if (reset || (advance && last_ff)) begin
         page_ff      <= '0;
         usage_ff     <= '0;
         size_ff      <= '0;
         count_ff     <= '0;
         offset_ff    <= '0;
         depth_ff     <= '0;
         in_ptr_ff    <= 1'b0;
         found_btn_ff <= 1'b0;
         found_ax_ff  <= 1'b0;
         found_wh_ff  <= 1'b0;
         id_seen_ff   <= 1'b0;
         finished_ff  <= 1'b0;
         btn_byte_ff  <= '0;
         btn_bits_ff  <= '0;
         btn_count_ff <= '0;
         ax_byte_ff   <= '0;
         ax_bits_ff   <= '0;
         wh_byte_ff   <= '0;
         wh_bits_ff   <= '0;
      end else if (advance) begin
         page_ff      <= page_in;
         usage_ff     <= usage_in;
         size_ff      <= size_in;
         count_ff     <= count_in;
         offset_ff    <= offset_in;
         depth_ff     <= depth_in;
         in_ptr_ff    <= in_ptr_in;
         found_btn_ff <= found_btn_in;
         found_ax_ff  <= found_ax_in;
         found_wh_ff  <= found_wh_in;
         id_seen_ff   <= id_seen_in;
         finished_ff  <= finished_in;
         btn_byte_ff  <= btn_byte_in;
         btn_bits_ff  <= btn_bits_in;
         btn_count_ff <= btn_count_in;
         ax_byte_ff   <= ax_byte_in;
         ax_bits_ff   <= ax_bits_in;
         wh_byte_ff   <= wh_byte_in;
         wh_bits_ff   <= wh_bits_in;
      end
   end

   // ------------------------------------------------------------------
   // Result register. It holds a finished item until the sink takes it;
   // while it waits, the parse step stalls and the input register fills.
   // ------------------------------------------------------------------
   hmdp_rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && emit_now) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit_now) begin
         rsp_ff <= result;
      end
   end

   assign rsp_if.valid              = rsp_valid_ff;
   assign rsp_if.status             = rsp_ff.status;
   assign rsp_if.button_byte        = rsp_ff.button_byte;
   assign rsp_if.button_bits        = rsp_ff.button_bits;
   assign rsp_if.button_count       = rsp_ff.button_count;
   assign rsp_if.axis_byte          = rsp_ff.axis_byte;
   assign rsp_if.axis_bits          = rsp_ff.axis_bits;
   assign rsp_if.wheel_found        = rsp_ff.wheel_found;
   assign rsp_if.wheel_byte         = rsp_ff.wheel_byte;
   assign rsp_if.wheel_bits         = rsp_ff.wheel_bits;
   assign rsp_if.report_bytes       = rsp_ff.report_bytes;
   assign rsp_if.report_id_declared = rsp_ff.report_id_declared;

endmodule

`default_nettype wire

>>> rtl/hmdp_checker.sv
// Port-level checks for the HID mouse descriptor parser and the bind that attaches
// them to hid_mouse_descriptor_parser_top. Depends on hmdp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hmdp_port_assert
   import hmdp_pkg::*;
(
   input wire                clock,
   input wire                reset,
   input wire                rsp_valid,
   input wire                rsp_ready,
   input wire                status,
   input wire [BYTE_W-1:0]   button_byte,
   input wire [BITS_W-1:0]   button_bits,
   input wire [COUNT_W-1:0]  button_count,
   input wire [BYTE_W-1:0]   axis_byte,
   input wire [AXBITS_W-1:0] axis_bits,
   input wire                wheel_found,
   input wire [BYTE_W-1:0]   wheel_byte,
   input wire [BITS_W-1:0]   wheel_bits,
   input wire [RLEN_W-1:0]   report_bytes,
   input wire                report_id_declared
);

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // A failed parse carries nothing but its status.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status |->
         button_byte == '0 && button_bits == '0 && button_count == '0 &&
         axis_byte == '0 && axis_bits == '0 && !wheel_found && wheel_byte == '0 &&
         wheel_bits == '0 && report_bytes == '0 && !report_id_declared)
      else $error("failed result has nonzero fields");

   // A good parse always has an 8- or 16-bit axis field.
   a_axis_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !status |-> (axis_bits == 5'd8 || axis_bits == 5'd16))
      else $error("axis size is neither 8 nor 16");

   // Without a wheel, its location fields are zero.
   a_no_wheel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !wheel_found |-> wheel_byte == '0 && wheel_bits == '0)
      else $error("wheel fields set without a wheel");

endmodule

bind hid_mouse_descriptor_parser_top hmdp_port_assert u_hmdp_port_assert (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_if.valid),
   .rsp_ready          (rsp_if.ready),
   .status             (rsp_if.status),
   .button_byte        (rsp_if.button_byte),
   .button_bits        (rsp_if.button_bits),
   .button_count       (rsp_if.button_count),
   .axis_byte          (rsp_if.axis_byte),
   .axis_bits          (rsp_if.axis_bits),
   .wheel_found        (rsp_if.wheel_found),
   .wheel_byte         (rsp_if.wheel_byte),
   .wheel_bits         (rsp_if.wheel_bits),
   .report_bytes       (rsp_if.report_bytes),
   .report_id_declared (rsp_if.report_id_declared)
);

`default_nettype wire
